// File: hw/rtl/buzzer_effect_sequencer_top_macros.svh
// assertion macros for the buzzer effect sequencer
// used by buzzer_effect_sequencer_top, no other dependencies
`ifndef BUZZER_EFFECT_SEQUENCER_TOP_MACROS_SVH
`define BUZZER_EFFECT_SEQUENCER_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define BES_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define BES_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/bes_pkg.sv
// types, command codes and the note rom of the buzzer effect sequencer
// no dependencies
package bes_pkg;

  localparam int unsigned CmdW  = 2;
  localparam int unsigned IdW   = 5;
  localparam int unsigned ToneW = 12;
  localparam int unsigned MsW   = 9;
  localparam int unsigned IdxW  = 5;
  localparam int unsigned CfgIdxW = 2;

  typedef logic [CmdW-1:0]    cmd_t;
  typedef logic [IdW-1:0]     effect_id_t;
  typedef logic [ToneW-1:0]   tone_t;
  typedef logic [MsW-1:0]     ms_t;
  typedef logic [IdxW-1:0]    note_idx_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  localparam cmd_t CMD_TICK = 2'd0;
  localparam cmd_t CMD_PLAY = 2'd1;
  localparam cmd_t CMD_STOP = 2'd2;

  localparam cfg_idx_t REG_SOUND_EN = 2'd0;
  localparam cfg_idx_t REG_UI_EN    = 2'd1;
  localparam cfg_idx_t REG_GAME_EN  = 2'd2;

  localparam effect_id_t GAME_FIRST = 5'd7;
  localparam effect_id_t GAME_LAST  = 5'd16;

  localparam tone_t P_REST = 12'd0;
  localparam tone_t P_G4 = 12'd392;
  localparam tone_t P_C6 = 12'd1047;
  localparam tone_t P_E6 = 12'd1319;
  localparam tone_t P_G6 = 12'd1568;
  localparam tone_t P_A6 = 12'd1760;
  localparam tone_t P_C7 = 12'd2093;
  localparam tone_t P_D7 = 12'd2349;
  localparam tone_t P_E7 = 12'd2637;
  localparam tone_t P_F7 = 12'd2794;
  localparam tone_t P_G7 = 12'd3136;

  typedef struct packed {
    tone_t hz;
    ms_t   ms;
  } note_t;

  // note rom, a zero duration marks the end of an effect
  function automatic note_t rom_note(input effect_id_t row, input note_idx_t idx);
    note_t n;
    case ({row, idx})
      {5'd0, 5'd0}:  n = '{P_E6, 9'd90};
      {5'd0, 5'd1}:  n = '{P_REST, 9'd25};
      {5'd0, 5'd2}:  n = '{P_E6, 9'd90};
      {5'd0, 5'd3}:  n = '{P_REST, 9'd25};
      {5'd0, 5'd4}:  n = '{P_G6, 9'd150};
      {5'd0, 5'd5}:  n = '{P_REST, 9'd30};
      {5'd0, 5'd6}:  n = '{P_C7, 9'd110};
      {5'd0, 5'd7}:  n = '{P_REST, 9'd20};
      {5'd0, 5'd8}:  n = '{P_E7, 9'd110};
      {5'd0, 5'd9}:  n = '{P_REST, 9'd20};
      {5'd0, 5'd10}: n = '{P_G7, 9'd220};
      {5'd0, 5'd11}: n = '{P_REST, 9'd60};
      {5'd0, 5'd12}: n = '{P_F7, 9'd110};
      {5'd0, 5'd13}: n = '{P_REST, 9'd20};
      {5'd0, 5'd14}: n = '{P_D7, 9'd110};
      {5'd0, 5'd15}: n = '{P_REST, 9'd20};
      {5'd0, 5'd16}: n = '{P_G6, 9'd90};
      {5'd0, 5'd17}: n = '{P_REST, 9'd25};
      {5'd0, 5'd18}: n = '{P_C7, 9'd340};
      {5'd1, 5'd0}:  n = '{P_A6, 9'd25};
      {5'd2, 5'd0}:  n = '{P_E6, 9'd25};
      {5'd3, 5'd0}:  n = '{P_G6, 9'd60};
      {5'd3, 5'd1}:  n = '{P_C7, 9'd90};
      {5'd4, 5'd0}:  n = '{P_C7, 9'd60};
      {5'd4, 5'd1}:  n = '{P_G6, 9'd90};
      {5'd5, 5'd0}:  n = '{P_E6, 9'd30};
      {5'd5, 5'd1}:  n = '{P_A6, 9'd45};
      {5'd6, 5'd0}:  n = '{P_C7, 9'd45};
      {5'd7, 5'd0}:  n = '{P_C6, 9'd60};
      {5'd7, 5'd1}:  n = '{P_G6, 9'd60};
      {5'd7, 5'd2}:  n = '{P_C7, 9'd110};
      {5'd8, 5'd0}:  n = '{P_A6, 9'd50};
      {5'd8, 5'd1}:  n = '{P_E6, 9'd80};
      {5'd9, 5'd0}:  n = '{P_E6, 9'd50};
      {5'd9, 5'd1}:  n = '{P_A6, 9'd80};
      {5'd10, 5'd0}: n = '{P_G6, 9'd110};
      {5'd10, 5'd1}: n = '{P_E6, 9'd110};
      {5'd10, 5'd2}: n = '{P_C6, 9'd110};
      {5'd10, 5'd3}: n = '{P_G4, 9'd260};
      {5'd11, 5'd0}: n = '{P_E6, 9'd14};
      {5'd12, 5'd0}: n = '{P_A6, 9'd18};
      {5'd13, 5'd0}: n = '{P_C6, 9'd40};
      {5'd14, 5'd0}: n = '{P_C6, 9'd45};
      {5'd14, 5'd1}: n = '{P_G6, 9'd45};
      {5'd14, 5'd2}: n = '{P_C7, 9'd70};
      {5'd15, 5'd0}: n = '{P_C6, 9'd40};
      {5'd15, 5'd1}: n = '{P_E6, 9'd40};
      {5'd15, 5'd2}: n = '{P_G6, 9'd40};
      {5'd15, 5'd3}: n = '{P_C7, 9'd40};
      {5'd15, 5'd4}: n = '{P_E7, 9'd120};
      {5'd16, 5'd0}: n = '{P_G6, 9'd50};
      {5'd16, 5'd1}: n = '{P_C7, 9'd50};
      {5'd16, 5'd2}: n = '{P_E7, 9'd110};
      {5'd17, 5'd0}: n = '{P_C6, 9'd55};
      {5'd17, 5'd1}: n = '{P_REST, 9'd15};
      {5'd17, 5'd2}: n = '{P_G6, 9'd90};
      {5'd18, 5'd0}: n = '{P_G6, 9'd55};
      {5'd18, 5'd1}: n = '{P_REST, 9'd15};
      {5'd18, 5'd2}: n = '{P_C6, 9'd110};
      {5'd19, 5'd0}: n = '{P_G6, 9'd55};
      {5'd19, 5'd1}: n = '{P_REST, 9'd15};
      {5'd19, 5'd2}: n = '{P_D7, 9'd90};
      {5'd20, 5'd0}: n = '{P_D7, 9'd55};
      {5'd20, 5'd1}: n = '{P_REST, 9'd15};
      {5'd20, 5'd2}: n = '{P_G6, 9'd110};
      {5'd21, 5'd0}: n = '{P_A6, 9'd90};
      {5'd21, 5'd1}: n = '{P_REST, 9'd25};
      {5'd21, 5'd2}: n = '{P_E6, 9'd90};
      {5'd21, 5'd3}: n = '{P_REST, 9'd25};
      {5'd21, 5'd4}: n = '{P_C6, 9'd200};
      {5'd22, 5'd0}: n = '{P_C6, 9'd70};
      {5'd22, 5'd1}: n = '{P_REST, 9'd20};
      {5'd22, 5'd2}: n = '{P_E6, 9'd70};
      {5'd22, 5'd3}: n = '{P_REST, 9'd20};
      {5'd22, 5'd4}: n = '{P_A6, 9'd160};
      default:       n = '{P_REST, 9'd0};
    endcase
    return n;
  endfunction

endpackage

// File: hw/rtl/buzzer_effect_sequencer_top.sv
// buzzer effect sequencer: an accepted request's result is registered and shows in the cycle after
// throughput one request per cycle while the result channel does not stall; a rom lookup and the ms counter update sit
// between the input handshake and the result register, the state updates on accept
// the result register frees as it is taken, so s_axis_tready only drops under stall
// rst (synchronous, active high) clears playback state, empties the result register
// and sets all three enable registers to one; depends on bes_pkg and the macros header
`include "buzzer_effect_sequencer_top_macros.svh"

module buzzer_effect_sequencer_top #(
  parameter int unsigned NUM_EFFECTS = 23
) (
  input  logic                   clk,
  input  logic                   rst,
  // request channel
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,   // command[1:0], effect_id[6:2], buzzer_ready[7]
  // result channel
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [15:0]            m_axis_tdata,   // tone_hz[11:0], playing[12], zero[15:13]
  // configuration writes
  input  logic                   cfg_we,
  input  bes_pkg::cfg_idx_t      cfg_index,
  input  logic [0:0]             cfg_data
);
  import bes_pkg::*;

  // id compare needs one bit more so that 32 effects fit
  localparam logic [IdW:0] NumEffects = (IdW+1)'(NUM_EFFECTS);

  // request fields
  cmd_t       in_cmd;
  effect_id_t in_id;
  logic       in_ready;
  logic       in_acc;

  assign in_cmd   = s_axis_tdata[1:0];
  assign in_id    = s_axis_tdata[6:2];
  assign in_ready = s_axis_tdata[7];

  // enable registers
  logic sound_en, ui_en, game_en;

  // playback state
  logic       active, active_next;
  effect_id_t current_effect, current_effect_next;
  note_idx_t  note_index, note_index_next;
  ms_t        time_left, time_left_next;
  tone_t      current_tone, current_tone_next;

  // result register
  logic  out_valid;
  tone_t out_tone;
  logic  out_playing;

  // rom lookup: play reads note zero of the new effect, a tick reads the next note
  effect_id_t lookup_row;
  note_idx_t  lookup_idx;
  note_t      note;
  logic       note_end;
  logic       is_game, cat_on, play_ok;

  // the result register takes a new request whenever it is empty or being drained
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign is_game = (in_id >= GAME_FIRST) && (in_id <= GAME_LAST);
  assign cat_on  = is_game ? game_en : ui_en;
  assign play_ok = sound_en && ({1'b0, in_id} < NumEffects) && in_ready && cat_on;

  assign lookup_row = (in_cmd == CMD_PLAY) ? in_id : current_effect;
  assign lookup_idx = (in_cmd == CMD_PLAY) ? '0 : note_index;
  assign note       = rom_note(lookup_row, lookup_idx);
  assign note_end   = (note.ms == '0);

  always_comb begin
    active_next         = active;
    current_effect_next = current_effect;
    note_index_next     = note_index;
    time_left_next      = time_left;
    current_tone_next   = current_tone;
    case (in_cmd)
      CMD_TICK: begin
        if (active) begin
          if (time_left <= ms_t'(1)) begin
            // time ran out: next note, or end of the effect
            if (note_end) begin
              active_next       = 1'b0;
              current_tone_next = '0;
              time_left_next    = '0;
            end else begin
              current_tone_next = note.hz;
              time_left_next    = note.ms;
              note_index_next   = lookup_idx + note_idx_t'(1);
            end
          end else begin
            time_left_next = time_left - ms_t'(1);
          end
        end
      end
      CMD_PLAY: begin
        if (play_ok) begin
          current_effect_next = in_id;
          if (note_end) begin
            // effect with no notes ends at once
            active_next       = 1'b0;
            note_index_next   = '0;
            current_tone_next = '0;
            time_left_next    = '0;
          end else begin
            active_next       = 1'b1;
            current_tone_next = note.hz;
            time_left_next    = note.ms;
            note_index_next   = note_idx_t'(1);
          end
        end
      end
      CMD_STOP: begin
        active_next       = 1'b0;
        current_tone_next = '0;
        time_left_next    = '0;
      end
      default: begin
        // unused command leaves everything as is
      end
    endcase
  end

  // enables
  always_ff @(posedge clk) begin
    if (rst) begin
      sound_en <= 1'b1;
      ui_en    <= 1'b1;
      game_en  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SOUND_EN: sound_en <= cfg_data[0];
        REG_UI_EN:    ui_en    <= cfg_data[0];
        REG_GAME_EN:  game_en  <= cfg_data[0];
        default:      ;
      endcase
    end
  end

  // playback state advances only on an accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      active         <= 1'b0;
      current_effect <= '0;
      note_index     <= '0;
      time_left      <= '0;
      current_tone   <= '0;
    end else if (in_acc) begin
      active         <= active_next;
      current_effect <= current_effect_next;
      note_index     <= note_index_next;
      time_left      <= time_left_next;
      current_tone   <= current_tone_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_tone    <= current_tone_next;
      out_playing <= active_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_playing, out_tone};

  // checks
  `BES_ASSERT_NOW(a_idle_silent, clk, rst, !active,
                  (current_tone == '0) && (time_left == '0), "idle with tone or time left")
  `BES_ASSERT_NOW(a_active_time, clk, rst, active, time_left != '0,
                  "active note with no time left")
  `BES_ASSERT_NEXT(a_result_follows, clk, rst, in_acc,
                   m_axis_tvalid && (out_playing == active), "result does not match state")
  `BES_ASSERT_NEXT(a_stop_silences, clk, rst, in_acc && (in_cmd == CMD_STOP),
                   !active && (out_tone == '0), "stop left buzzer on")

endmodule
